[hdl/npcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcs_pkg
// shared types, widths and codes for the nearest palette colour search core
// ----------------------------------------------------------------------------
package npcs_pkg;

  // palette geometry
  localparam int PAL_DEPTH = 256;
  localparam int IDX_W     = $clog2(PAL_DEPTH);
  localparam int COUNT_W   = 9;
  localparam int EFF_MAX   = (PAL_DEPTH < 256) ? PAL_DEPTH : 256;
  localparam int CMP_W     = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;

  // colour and distance widths
  localparam int COMP_W    = 8;
  localparam int ENTRY_W   = 3 * COMP_W;
  localparam int SQ_W      = 2 * COMP_W;
  localparam int WT_W      = 10;
  localparam int PROD_W    = WT_W + SQ_W;
  localparam int PROD_SHIFT = 8;
  localparam int G4_W      = SQ_W + 2;
  localparam int DIST_W    = 20;

  // redmean weights
  localparam logic [WT_W-1:0] WR_BASE = 10'd512;
  localparam logic [WT_W-1:0] WB_BASE = 10'd767;
  localparam int GREEN_SHIFT = 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_INDEX   = 2'd2;

  // transaction kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_WRITE_DONE  = 2'd0;
  localparam logic [1:0] STATUS_MATCH       = 2'd1;
  localparam logic [1:0] STATUS_WRITE_RANGE = 2'd2;
  localparam logic [1:0] STATUS_NO_ENTRY    = 2'd3;

  // tag travelling with each scanned entry through the distance pipeline
  typedef struct packed {
    logic             valid;
    logic             elig;
    logic             last;
    logic [IDX_W-1:0] idx;
  } scan_tag_t;

endpackage

[hdl/npcs_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcs_cell
// one palette entry of the rotating ring; loads on a write, passes on a scan
// ----------------------------------------------------------------------------
module npcs_cell
  import npcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               shift_en,
  input  logic               load_en,
  input  logic [ENTRY_W-1:0] load_rgb,
  input  logic [ENTRY_W-1:0] nb_rgb,
  output logic [ENTRY_W-1:0] rgb
);

  logic [ENTRY_W-1:0] rgb_r;
  logic [ENTRY_W-1:0] rgb_nxt;

  // shift from the neighbour during a scan, else take a write
  always_comb begin
    rgb_nxt = rgb_r;
    if (shift_en) begin
      rgb_nxt = nb_rgb;
    end else if (load_en) begin
      rgb_nxt = load_rgb;
    end
  end

  // entries reset to black
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rgb_r <= '0;
    end else begin
      rgb_r <= rgb_nxt;
    end
  end

  assign rgb = rgb_r;

endmodule

[hdl/npcs_dist.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npcs_dist
// four-stage pipeline scoring one palette entry per cycle with the
// redmean-weighted squared distance
// ----------------------------------------------------------------------------
module npcs_dist
  import npcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  scan_tag_t          tag_in,
  input  logic [ENTRY_W-1:0] entry_rgb,
  input  logic [ENTRY_W-1:0] query_rgb,
  output scan_tag_t          tag_out,
  output logic [DIST_W-1:0]  score
);

  scan_tag_t s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r;

  logic [COMP_W-1:0] qr, qg, qb, er, eg, eb;
  logic [COMP_W-1:0] rmean_nxt, dr_nxt, dg_nxt, db_nxt;
  logic [COMP_W-1:0] s1_rmean_r, s1_dr_r, s1_dg_r, s1_db_r;

  logic [SQ_W-1:0]   rs_nxt, gs_nxt, bs_nxt;
  logic [WT_W-1:0]   wr_nxt, wb_nxt;
  logic [SQ_W-1:0]   s2_rs_r, s2_gs_r, s2_bs_r;
  logic [WT_W-1:0]   s2_wr_r, s2_wb_r;

  logic [PROD_W-1:0] pr_nxt, pb_nxt;
  logic [G4_W-1:0]   g4_nxt;
  logic [PROD_W-1:0] s3_pr_r, s3_pb_r;
  logic [G4_W-1:0]   s3_g4_r;

  logic [DIST_W-1:0] dist_nxt;
  logic [DIST_W-1:0] s4_dist_r;

  assign {qr, qg, qb} = query_rgb;
  assign {er, eg, eb} = entry_rgb;

  // stage 1: red mean and absolute differences
  always_comb begin
    rmean_nxt = COMP_W'(({1'b0, qr} + {1'b0, er}) >> 1);
    dr_nxt    = (qr > er) ? (qr - er) : (er - qr);
    dg_nxt    = (qg > eg) ? (qg - eg) : (eg - qg);
    db_nxt    = (qb > eb) ? (qb - eb) : (eb - qb);
  end

  // stage 2: squares and red/blue weights
  always_comb begin
    rs_nxt = SQ_W'(s1_dr_r) * SQ_W'(s1_dr_r);
    gs_nxt = SQ_W'(s1_dg_r) * SQ_W'(s1_dg_r);
    bs_nxt = SQ_W'(s1_db_r) * SQ_W'(s1_db_r);
    wr_nxt = WR_BASE + WT_W'(s1_rmean_r);
    wb_nxt = WB_BASE - WT_W'(s1_rmean_r);
  end

  // stage 3: weighted products
  always_comb begin
    pr_nxt = PROD_W'(s2_wr_r) * PROD_W'(s2_rs_r);
    pb_nxt = PROD_W'(s2_wb_r) * PROD_W'(s2_bs_r);
    g4_nxt = G4_W'(s2_gs_r) << GREEN_SHIFT;
  end

  // stage 4: final sum
  always_comb begin
    dist_nxt = DIST_W'(s3_pr_r >> PROD_SHIFT) + DIST_W'(s3_g4_r)
             + DIST_W'(s3_pb_r >> PROD_SHIFT);
  end

  // tag pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
      s3_tag_r <= '0;
      s4_tag_r <= '0;
    end else begin
      s1_tag_r <= tag_in;
      s2_tag_r <= s1_tag_r;
      s3_tag_r <= s2_tag_r;
      s4_tag_r <= s3_tag_r;
    end
  end

  // data pipeline
  always_ff @(posedge clk) begin
    s1_rmean_r <= rmean_nxt;
    s1_dr_r    <= dr_nxt;
    s1_dg_r    <= dg_nxt;
    s1_db_r    <= db_nxt;
    s2_rs_r    <= rs_nxt;
    s2_gs_r    <= gs_nxt;
    s2_bs_r    <= bs_nxt;
    s2_wr_r    <= wr_nxt;
    s2_wb_r    <= wb_nxt;
    s3_pr_r    <= pr_nxt;
    s3_pb_r    <= pb_nxt;
    s3_g4_r    <= g4_nxt;
    s4_dist_r  <= dist_nxt;
  end

  assign tag_out = s4_tag_r;
  assign score   = s4_dist_r;

endmodule

[hdl/nearest_palette_color_search_core.sv]
`timescale 1ns / 1ps
// Write transaction: the status is registered as pending, then moved into the output register.
// Query transaction: the palette ring rotates one entry a cycle past the distance pipeline
// over all PAL_DEPTH entries, then the result passes the running minimum and the output register.
// A new transaction is accepted only in the idle state, once the previous result is registered.
// Synchronous active-low reset sets all entries to black, count 256, colour key off.
// ----------------------------------------------------------------------------
// nearest_palette_color_search_core
// palette store and redmean-weighted nearest colour search over a ring of cells
// ----------------------------------------------------------------------------
module nearest_palette_color_search_core
  import npcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  input  logic [7:0]            in_entry_index,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [7:0]            out_best_index,
  // configuration port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] color_count_r;
  logic               key_enable_r;
  logic [7:0]         key_index_r;
  logic [COUNT_W-1:0] n_eff;
  logic [ENTRY_W-1:0] query_rgb_r;
  logic [1:0]         pend_status_r, pend_status_nxt;
  logic [7:0]         pend_idx_r, pend_idx_nxt;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [7:0]         out_best_index_r;
  logic               accept, wr_accept, q_accept, wr_in_range, shift_en;
  logic [ENTRY_W-1:0] in_rgb;
  logic [ENTRY_W-1:0] ring_rgb [PAL_DEPTH];
  scan_tag_t          scan_tag, res_tag;
  logic [DIST_W-1:0]  res_dist;
  logic               found_r, fin_r;
  logic [DIST_W-1:0]  best_d_r;
  logic [IDX_W-1:0]   best_i_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_count_r <= COUNT_W'(256);
      key_enable_r  <= 1'b0;
      key_index_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_COLOR_COUNT: color_count_r <= cfg_data;
        REG_KEY_ENABLE:  key_enable_r  <= cfg_data[0];
        REG_KEY_INDEX:   key_index_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // effective count, saturated to the palette and index reach
  assign n_eff = (CMP_W'(color_count_r) > CMP_W'(EFF_MAX)) ? COUNT_W'(EFF_MAX)
                                                         : color_count_r;

  // input handshake
  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign wr_accept   = accept && (in_kind == KIND_WRITE);
  assign q_accept    = accept && (in_kind == KIND_QUERY);
  assign wr_in_range = CMP_W'(in_entry_index) < CMP_W'(n_eff);
  assign in_rgb      = {in_red, in_green, in_blue};
  assign shift_en    = (state_r == S_SCAN);

  // ring of palette cells, each passes its entry towards cell 0 while scanning
  for (genvar g = 0; g < PAL_DEPTH; g++) begin : g_cell
    npcs_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .load_en  (wr_accept && wr_in_range && (CMP_W'(in_entry_index) == CMP_W'(g))),
      .load_rgb (in_rgb),
      .nb_rgb   (ring_rgb[(g + 1) % PAL_DEPTH]),
      .rgb      (ring_rgb[g])
    );
  end

  // tag for the entry now at the head of the ring
  always_comb begin
    scan_tag.valid = (state_r == S_SCAN);
    scan_tag.idx   = cnt_r;
    scan_tag.last  = (cnt_r == IDX_W'(PAL_DEPTH - 1));
    scan_tag.elig  = (CMP_W'(cnt_r) < CMP_W'(n_eff))
                  && !(key_enable_r && (CMP_W'(cnt_r) == CMP_W'(key_index_r)));
  end

  // query colour held for the whole scan
  always_ff @(posedge clk) begin
    if (q_accept) begin
      query_rgb_r <= in_rgb;
    end
  end

  npcs_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_in    (scan_tag),
    .entry_rgb (ring_rgb[0]),
    .query_rgb (query_rgb_r),
    .tag_out   (res_tag),
    .score     (res_dist)
  );

  // running minimum, strict compare keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      fin_r   <= 1'b0;
    end else begin
      fin_r <= res_tag.valid && res_tag.last;
      if (q_accept) begin
        found_r <= 1'b0;
      end else if (res_tag.valid && res_tag.elig && (!found_r || (res_dist < best_d_r))) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_tag.valid && res_tag.elig && (!found_r || (res_dist < best_d_r))) begin
      best_d_r <= res_dist;
      best_i_r <= res_tag.idx;
    end
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    pend_status_nxt = pend_status_r;
    pend_idx_nxt    = pend_idx_r;
    case (state_r)
      S_IDLE: begin
        if (wr_accept) begin
          pend_status_nxt = wr_in_range ? STATUS_WRITE_DONE : STATUS_WRITE_RANGE;
          pend_idx_nxt    = '0;
          state_nxt       = S_DONE;
        end else if (q_accept) begin
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        if (scan_tag.last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (fin_r) begin
          pend_status_nxt = found_r ? STATUS_MATCH : STATUS_NO_ENTRY;
          pend_idx_nxt    = found_r ? 8'(best_i_r) : 8'd0;
          state_nxt       = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    pend_idx_r    <= pend_idx_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      out_status_r     <= pend_status_r;
      out_best_index_r <= pend_idx_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_best_index = out_best_index_r;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// regression for the nearest palette colour search core: a directed set of
// palette writes and queries, then randomised phases under several register
// settings. Every result is checked against a behavioural palette model.
// ----------------------------------------------------------------------------
module tb_top
  import npcs_pkg::*;
;

  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned PHASE_ITEMS  = 180;
  // register index beyond the three real registers, writes are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } palette_request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] best_index;
  } palette_result_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // dut ports
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic                  in_kind        = KIND_WRITE;
  logic [7:0]            in_entry_index = '0;
  logic [7:0]            in_red         = '0;
  logic [7:0]            in_green       = '0;
  logic [7:0]            in_blue        = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [1:0]            out_status;
  logic [7:0]            out_best_index;
  logic                  cfg_wr_en      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = REG_COLOR_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  // palette model and register copies
  logic [ENTRY_W-1:0] palette_model [PAL_DEPTH];
  logic [8:0]         model_count   = 9'd256;
  logic               model_key_en  = 1'b0;
  logic [7:0]         model_key_idx = 8'd0;

  // stimulus and scoreboard
  palette_request_t pending_requests [$];
  palette_result_t  expected_results [$];
  int unsigned      requests_queued = 0;
  int unsigned      results_checked = 0;
  int unsigned      error_count     = 0;
  int unsigned      cycle_count     = 0;
  bit               pace_bursts     = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  nearest_palette_color_search_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_best_index (out_best_index),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // entries taking part in searches and writes
  function automatic int unsigned usable_entries();
    return (model_count > EFF_MAX) ? EFF_MAX : int'(model_count);
  endfunction

  // redmean weighted squared distance between two colours
  function automatic int unsigned redmean_score(int unsigned r1, int unsigned g1,
                                                int unsigned b1, int unsigned r2,
                                                int unsigned g2, int unsigned b2);
    int unsigned rmean, dr, dg, db;
    rmean = (r1 + r2) >> 1;
    dr    = (r1 > r2) ? r1 - r2 : r2 - r1;
    dg    = (g1 > g2) ? g1 - g2 : g2 - g1;
    db    = (b1 > b2) ? b1 - b2 : b2 - b1;
    return (((int'(WR_BASE) + rmean) * dr * dr) >> 8) + 4 * dg * dg
         + (((int'(WB_BASE) - rmean) * db * db) >> 8);
  endfunction

  // apply one transaction to the palette model and give its result
  function automatic palette_result_t apply_palette_request(palette_request_t req);
    palette_result_t    res;
    int unsigned        eff, score, best_score, best_idx;
    bit                 found;
    logic [ENTRY_W-1:0] ent;
    res.status     = STATUS_WRITE_DONE;
    res.best_index = '0;
    eff            = usable_entries();
    found          = 1'b0;
    best_score     = 0;
    best_idx       = 0;
    if (req.kind == KIND_WRITE) begin
      if (req.entry_index < eff)
        palette_model[req.entry_index] = {req.red, req.green, req.blue};
      else
        res.status = STATUS_WRITE_RANGE;
    end else begin
      for (int i = 0; i < eff; i++) begin
        if (model_key_en && i == model_key_idx)
          continue;
        ent   = palette_model[IDX_W'(i)];
        score = redmean_score(req.red, req.green, req.blue,
                              ent[23:16], ent[15:8], ent[7:0]);
        // strict compare keeps the lowest index on a tie
        if (!found || score < best_score) begin
          found      = 1'b1;
          best_score = score;
          best_idx   = i;
        end
      end
      if (found) begin
        res.status     = STATUS_MATCH;
        res.best_index = best_idx[7:0];
      end else begin
        res.status = STATUS_NO_ENTRY;
      end
    end
    return res;
  endfunction

  // colour component biased towards the extremes
  function automatic logic [7:0] pick_component();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // component shifted a little, clamped to the 8-bit range
  function automatic logic [7:0] nudge_component(logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 12)) - 6;
    if (v < 0)
      v = 0;
    if (v > 255)
      v = 255;
    return 8'(v);
  endfunction

  task automatic push_request(logic kind, logic [7:0] idx, logic [7:0] r,
                              logic [7:0] g, logic [7:0] b);
    palette_request_t req;
    req = '{kind, idx, r, g, b};
    pending_requests = {pending_requests, req};
    requests_queued++;
  endtask

  // configuration write, model follows at the edge the dut samples it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_COLOR_COUNT: model_count   = data;
      REG_KEY_ENABLE:  model_key_en  = data[0];
      REG_KEY_INDEX:   model_key_idx = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [8:0] count, logic key_en, logic [7:0] key_idx);
    write_reg(REG_COLOR_COUNT, count);
    write_reg(REG_KEY_ENABLE, {8'd0, key_en});
    write_reg(REG_KEY_INDEX, {1'b0, key_idx});
  endtask

  // hold until every queued transaction has produced its result
  task automatic wait_until_drained();
    while (results_checked != requests_queued)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // random phase: a burst of writes to populate, then a write/query mix
  task automatic queue_random_items(int unsigned n_items);
    int unsigned        eff, fill;
    logic [7:0]         idx, r, g, b;
    logic [ENTRY_W-1:0] ent;
    eff  = usable_entries();
    fill = (eff < 16) ? eff : 16;
    for (int k = 0; k < n_items; k++) begin
      idx = 8'($urandom_range(0, 255));
      if (k < fill || $urandom_range(0, 9) < 4) begin
        if (eff > 0 && $urandom_range(0, 7) != 0)
          idx = 8'($urandom_range(0, eff - 1));
        if ($urandom_range(0, 4) == 0) begin
          // duplicate colour to provoke ties
          ent = palette_model[IDX_W'($urandom_range(0, PAL_DEPTH - 1))];
          {r, g, b} = ent;
        end else begin
          r = pick_component();
          g = pick_component();
          b = pick_component();
        end
        push_request(KIND_WRITE, idx, r, g, b);
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          ent = palette_model[IDX_W'($urandom_range(0, (eff > 0) ? eff - 1 : 0))];
          r   = nudge_component(ent[23:16]);
          g   = nudge_component(ent[15:8]);
          b   = nudge_component(ent[7:0]);
        end else begin
          r = pick_component();
          g = pick_component();
          b = pick_component();
        end
        push_request(KIND_QUERY, idx, r, g, b);
      end
    end
  endtask

  // driver: presents queued transactions, predicts on acceptance
  always @(posedge clk) begin : drive_requests
    palette_request_t cur_request;
    bit               presenting;
    int unsigned      send_gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      presenting = in_valid;
      if (in_valid && in_ready) begin
        expected_results = {expected_results, apply_palette_request(cur_request)};
        presenting = 1'b0;
      end
      if (!presenting) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_requests.size() > 0) begin
          cur_request    = pending_requests.pop_front();
          in_kind        <= cur_request.kind;
          in_entry_index <= cur_request.entry_index;
          in_red         <= cur_request.red;
          in_green       <= cur_request.green;
          in_blue        <= cur_request.blue;
          presenting     = 1'b1;
          if (pace_bursts && $urandom_range(0, 3) == 0)
            send_gap = $urandom_range(1, 14);
        end
      end
      in_valid <= presenting;
    end
  end

  // monitor: compares each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    palette_result_t exp_res;
    int unsigned     stall_left;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d best_index %0d",
                 out_status, out_best_index);
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_status !== exp_res.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   exp_res.status, out_status);
            error_count++;
          end
          if (out_best_index !== exp_res.best_index) begin
            $error("best_index mismatch: expected %0d, actual %0d",
                   exp_res.best_index, out_best_index);
            error_count++;
          end
          results_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (pace_bursts && $urandom_range(0, 4) == 0)
          stall_left = $urandom_range(1, 14);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("nearest_palette_color_search_core regression: fail");
    $finish;
  end

  // test sequence
  initial begin
    for (int i = 0; i < PAL_DEPTH; i++)
      palette_model[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // all-black palette ties everywhere, lowest index wins
    push_request(KIND_QUERY, 8'd0, 8'd0, 8'd0, 8'd0);
    push_request(KIND_WRITE, 8'd255, 8'd255, 8'd255, 8'd255);
    push_request(KIND_QUERY, 8'd0, 8'd255, 8'd255, 8'd255);
    push_request(KIND_WRITE, 8'd1, 8'd255, 8'd0, 8'd0);
    push_request(KIND_WRITE, 8'd2, 8'd0, 8'd255, 8'd0);
    push_request(KIND_WRITE, 8'd3, 8'd0, 8'd0, 8'd255);
    push_request(KIND_WRITE, 8'd4, 8'd255, 8'd0, 8'd0);
    push_request(KIND_QUERY, 8'd255, 8'd255, 8'd0, 8'd0);
    push_request(KIND_QUERY, 8'd0, 8'd0, 8'd255, 8'd0);
    push_request(KIND_QUERY, 8'd0, 8'd0, 8'd0, 8'd255);
    push_request(KIND_QUERY, 8'd0, 8'd128, 8'd128, 8'd128);
    wait_until_drained();

    // colour key skips the first red entry
    write_reg(REG_KEY_ENABLE, 9'd1);
    write_reg(REG_KEY_INDEX, 9'd1);
    push_request(KIND_QUERY, 8'd0, 8'd255, 8'd0, 8'd0);
    wait_until_drained();

    // key on the top entry, data bits above the field are dropped
    write_reg(REG_KEY_INDEX, 9'h1FF);
    push_request(KIND_QUERY, 8'd0, 8'd255, 8'd255, 8'd255);
    wait_until_drained();

    // key outside a short count excludes nothing, write above count refused
    set_config(9'd5, 1'b1, 8'd200);
    push_request(KIND_QUERY, 8'd0, 8'd255, 8'd255, 8'd255);
    push_request(KIND_WRITE, 8'd5, 8'd1, 8'd1, 8'd1);
    push_request(KIND_WRITE, 8'd4, 8'd255, 8'd255, 8'd255);
    push_request(KIND_QUERY, 8'd0, 8'd255, 8'd255, 8'd255);
    wait_until_drained();

    // empty palette
    set_config(9'd0, 1'b0, 8'd0);
    push_request(KIND_QUERY, 8'd0, 8'd10, 8'd20, 8'd30);
    push_request(KIND_WRITE, 8'd0, 8'd10, 8'd20, 8'd30);
    wait_until_drained();

    // key is the only entry
    set_config(9'd1, 1'b1, 8'd0);
    push_request(KIND_QUERY, 8'd0, 8'd10, 8'd20, 8'd30);
    push_request(KIND_WRITE, 8'd0, 8'd10, 8'd20, 8'd30);
    wait_until_drained();

    // count above the palette saturates, spare register has no effect
    write_reg(REG_COLOR_COUNT, 9'h1FF);
    write_reg(REG_KEY_ENABLE, 9'h1FE);
    write_reg(REG_SPARE, 9'h000);
    push_request(KIND_WRITE, 8'd255, 8'd1, 8'd2, 8'd3);
    push_request(KIND_QUERY, 8'd0, 8'd1, 8'd2, 8'd3);
    push_request(KIND_QUERY, 8'd0, 8'd255, 8'd0, 8'd0);
    wait_until_drained();

    // randomised phases over a spread of settings
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_config(9'd256, 1'b0, 8'd0);
        1: set_config(9'd256, 1'b1, 8'd0);
        2: set_config(9'd256, 1'b1, 8'd255);
        3: set_config(9'd2, 1'b1, 8'd1);
        4: set_config(9'd1, 1'b0, 8'd0);
        5: set_config(9'd511, 1'b1, 8'($urandom_range(0, 255)));
        6: set_config(9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)));
        7: set_config(9'd0, 1'b0, 8'd0);
        8: set_config(9'd37, 1'b1, 8'd200);
        default: set_config(9'd256, 1'b1, 8'($urandom_range(0, 255)));
      endcase
      // last phase runs at full rate on both sides
      pace_bursts = (ph == 9) ? 1'b0 : ($urandom_range(0, 3) != 0);
      queue_random_items(PHASE_ITEMS);
      wait_until_drained();
    end

    repeat (300) @(posedge clk);
    if (error_count == 0)
      $display("nearest_palette_color_search_core regression: pass");
    else
      $display("nearest_palette_color_search_core regression: fail");
    $finish;
  end

endmodule
